// ===== hw/rtl/sliding_window_slope_estimator_unit_assert.svh =====
// Assertion macros for the slope estimator.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef SLIDING_WINDOW_SLOPE_ESTIMATOR_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_SLOPE_ESTIMATOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define SWSE_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swse assertion failed");
// Next-cycle implication
`define SWSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swse assertion failed");
`else
`define SWSE_ASSERT(lbl, ante, cons)
`define SWSE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/swse_pkg.sv =====
`default_nettype none
package swse_pkg;

  // Field widths
  localparam int TickW   = 32;
  localparam int AltW    = 16;
  localparam int HgtW    = 17;
  localparam int SlopeW  = 32;
  localparam int FracW   = 16;

  // Default window length
  localparam int WindowDef = 16;

  // Shared multiplier: signed operands, full product
  localparam int MulW  = 34;
  localparam int ProdW = 2 * MulW;

  // Configuration port
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam logic RegGroundAltitude = 1'b0;

  // Saturation limits
  localparam logic [SlopeW-1:0] SlopeMax = 32'h7FFF_FFFF;
  localparam logic [SlopeW-1:0] SlopeMin = 32'h8000_0000;

  // Operand pair for the shared multiplier
  typedef struct packed {
    logic signed [MulW-1:0] a;
    logic signed [MulW-1:0] b;
  } mul_req_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [SlopeW-1:0] quot;
  } div_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sliding_window_slope_estimator_unit.sv =====
`default_nettype none
// Sliding-window least-squares slope estimator. Each input item (tick, raw
// altitude) is turned into a height above the ground altitude register,
// stored in a ring of WINDOW entries, and a line is fitted over the whole
// ring, unwritten entries counting as zero. The result item carries the
// height, the slope in signed 16.16 feet per tick (truncated, saturated) and
// a flag that is low when all ticks in the window are equal. Each item runs
// from accept to result through the states ST_RD, ST_TT and ST_TH per ring
// entry on the single shared multiplier, ST_TAIL for the last tick*height
// product, five multiplier steps for the cross terms, ST_FIN and ST_CHK to
// form and check the fit, then a restoring divider that retires one quotient
// bit per cycle over 68 + 2*log2(WINDOW) bits before ST_OUT hands over. When
// all ticks are equal the divider is skipped. The input is not ready until
// the result has moved to the output register, which can wait for the last
// result to drain; a finished result waits there while the next item is taken.
module sliding_window_slope_estimator_unit #(
  parameter int WINDOW = swse_pkg::WindowDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [swse_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [swse_pkg::ApbDataW-1:0] pwdata,
  output logic      [swse_pkg::ApbDataW-1:0] prdata,
  output logic                               pready,
  // Input items
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [31:0] sample_tick, [47:32] raw_altitude
  input  wire logic [47:0]                   s_axis_tdata_i,
  // Result items
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [16:0] height_above_ground, [48:17] climb_slope, [55:49] zero
  output logic      [55:0]                   m_axis_tdata_o,
  // [0] slope_valid
  output logic      [0:0]                    m_axis_tuser_o
);
  import swse_pkg::*;

  localparam int Lw    = $clog2(WINDOW);
  localparam int IdxW  = Lw;
  localparam int XsW   = TickW + Lw;
  localparam int YsW   = HgtW + Lw;
  localparam int XyW   = TickW + HgtW + 1 + Lw;
  localparam int XqW   = 2 * TickW + Lw;
  localparam int SqW   = 2 * XsW;
  localparam int HalfW = (XsW + 1) / 2;
  localparam int HiW   = XsW - HalfW;
  localparam int CsW   = XsW + YsW + 1;
  localparam int NumW  = TickW + HgtW + 3 + 2 * Lw;
  localparam int DenW  = 2 * TickW + 1 + 2 * Lw;
  localparam int DvdW  = NumW + FracW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_TT, ST_TH, ST_TAIL,
    ST_Q0, ST_Q1, ST_Q2, ST_Y0, ST_Y1,
    ST_FIN, ST_CHK, ST_DIV, ST_OUT
  } state_e;

  state_e                  state_q;
  logic [AltW-1:0]         ground_q;
  logic [IdxW-1:0]         wr_slot_q;
  logic [IdxW-1:0]         idx_q;
  logic [XsW-1:0]          xs_q;
  logic signed [YsW-1:0]   ys_q;
  logic signed [XyW-1:0]   xy_q;
  logic [XqW-1:0]          xq_q;
  logic [SqW-1:0]          sq_q;
  logic signed [CsW-1:0]   cs_q;
  logic signed [NumW-1:0]  num_q;
  logic [DenW-1:0]         den_q;
  logic signed [HgtW-1:0]  hgt_q;
  logic [SlopeW-1:0]       slope_q;
  logic                    sv_q;
  logic                    out_valid_q;
  logic signed [HgtW-1:0]  out_hgt_q;
  logic [SlopeW-1:0]       out_slope_q;
  logic                    out_sv_q;

  logic                    in_acc;
  logic                    cfg_wr;
  logic signed [HgtW-1:0]  hgt_d;
  logic [TickW-1:0]        rd_tick;
  logic signed [HgtW-1:0]  rd_hgt;
  mul_req_t                mreq;
  logic signed [ProdW-1:0] prod;
  logic [HalfW-1:0]        xs_lo;
  logic [HiW-1:0]          xs_hi;
  logic signed [CsW-1:0]   cs_sum;
  logic signed [NumW-1:0]  num_d;
  logic [DenW-1:0]         den_d;
  logic [NumW-1:0]         mag;
  logic                    div_start;
  div_res_t                div_res;
  logic                    sat;
  logic [SlopeW-1:0]       slope_d;

  // Handshakes
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_wr          = psel && penable && pwrite;
  assign pready          = 1'b1;
  assign prdata          = (paddr[2] == RegGroundAltitude) ?
                           ApbDataW'(ground_q) : '0;

  assign hgt_d = $signed({1'b0, s_axis_tdata_i[TickW+AltW-1:TickW]})
               - $signed({1'b0, ground_q});

  swse_ring #(.WINDOW(WINDOW)) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_acc),
    .wr_addr_i (wr_slot_q),
    .wr_tick_i (s_axis_tdata_i[TickW-1:0]),
    .wr_hgt_i  (hgt_d),
    .rd_en_i   (state_q == ST_RD),
    .rd_addr_i (idx_q),
    .rd_tick_o (rd_tick),
    .rd_hgt_o  (rd_hgt)
  );

  // Operand select for the shared multiplier
  assign xs_lo = xs_q[HalfW-1:0];
  assign xs_hi = xs_q[XsW-1:HalfW];

  always_comb begin
    mreq.a = '0;
    mreq.b = '0;
    case (state_q)
      ST_TT: begin
        mreq.a = MulW'($signed({1'b0, rd_tick}));
        mreq.b = MulW'($signed({1'b0, rd_tick}));
      end
      ST_TH: begin
        mreq.a = MulW'($signed({1'b0, rd_tick}));
        mreq.b = MulW'(rd_hgt);
      end
      ST_Q0: begin
        mreq.a = MulW'($signed({1'b0, xs_lo}));
        mreq.b = MulW'($signed({1'b0, xs_lo}));
      end
      ST_Q1: begin
        mreq.a = MulW'($signed({1'b0, xs_hi}));
        mreq.b = MulW'($signed({1'b0, xs_lo}));
      end
      ST_Q2: begin
        mreq.a = MulW'($signed({1'b0, xs_hi}));
        mreq.b = MulW'($signed({1'b0, xs_hi}));
      end
      ST_Y0: begin
        mreq.a = MulW'($signed({1'b0, xs_lo}));
        mreq.b = MulW'(ys_q);
      end
      ST_Y1: begin
        mreq.a = MulW'($signed({1'b0, xs_hi}));
        mreq.b = MulW'(ys_q);
      end
      default: begin
        mreq.a = '0;
        mreq.b = '0;
      end
    endcase
  end

  swse_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .prod_o (prod)
  );

  // Numerator and denominator of the fit
  assign cs_sum = cs_q + (CsW'(prod) <<< HalfW);
  assign num_d  = NumW'(xy_q) * $signed(NumW'(WINDOW)) - NumW'(cs_sum);
  assign den_d  = DenW'(xq_q) * DenW'(WINDOW) - DenW'(sq_q);

  // Divider: |num| * 2^16 / den
  assign mag       = num_q[NumW-1] ? NumW'(-num_q) : NumW'(num_q);
  assign div_start = (state_q == ST_CHK) && (den_q != '0);

  swse_div #(.NW(DvdW), .DW(DenW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({mag, {FracW{1'b0}}}),
    .divisor_i  (den_q),
    .res_o      (div_res)
  );

  // Sign and saturation
  always_comb begin
    if (num_q[NumW-1]) begin
      sat     = div_res.ovf || (div_res.quot > SlopeMin);
      slope_d = sat ? SlopeMin : SlopeW'(-div_res.quot);
    end else begin
      sat     = div_res.ovf || div_res.quot[SlopeW-1];
      slope_d = sat ? SlopeMax : div_res.quot;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ground_q    <= '0;
      wr_slot_q   <= '0;
      idx_q       <= '0;
      xs_q        <= '0;
      ys_q        <= '0;
      xy_q        <= '0;
      xq_q        <= '0;
      sq_q        <= '0;
      cs_q        <= '0;
      num_q       <= '0;
      den_q       <= '0;
      hgt_q       <= '0;
      slope_q     <= '0;
      sv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_hgt_q   <= '0;
      out_slope_q <= '0;
      out_sv_q    <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[2] == RegGroundAltitude)) begin
        ground_q <= pwdata[AltW-1:0];
      end
      // drained result; a new one from ST_OUT takes its place below
      if (out_valid_q && m_axis_tready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            hgt_q     <= hgt_d;
            wr_slot_q <= (wr_slot_q == IdxW'(WINDOW - 1)) ? '0 : wr_slot_q + 1'b1;
            idx_q     <= '0;
            xs_q      <= '0;
            ys_q      <= '0;
            xy_q      <= '0;
            xq_q      <= '0;
            state_q   <= ST_RD;
          end
        end
        ST_RD: begin
          // product of the previous entry's tick and height
          if (idx_q != '0) begin
            xy_q <= xy_q + XyW'(prod);
          end
          state_q <= ST_TT;
        end
        ST_TT: begin
          state_q <= ST_TH;
        end
        ST_TH: begin
          xq_q <= xq_q + XqW'(prod[2*TickW-1:0]);
          xs_q <= xs_q + XsW'(rd_tick);
          ys_q <= ys_q + YsW'(rd_hgt);
          if (idx_q == IdxW'(WINDOW - 1)) begin
            state_q <= ST_TAIL;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_RD;
          end
        end
        ST_TAIL: begin
          xy_q    <= xy_q + XyW'(prod);
          state_q <= ST_Q0;
        end
        ST_Q0: begin
          state_q <= ST_Q1;
        end
        ST_Q1: begin
          sq_q    <= SqW'(prod[2*HalfW-1:0]);
          state_q <= ST_Q2;
        end
        ST_Q2: begin
          sq_q    <= sq_q + (SqW'(prod[2*HalfW-1:0]) << (HalfW + 1));
          state_q <= ST_Y0;
        end
        ST_Y0: begin
          sq_q    <= sq_q + (SqW'(prod[2*HalfW-1:0]) << (2 * HalfW));
          state_q <= ST_Y1;
        end
        ST_Y1: begin
          cs_q    <= CsW'(prod);
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          num_q   <= num_d;
          den_q   <= den_d;
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          if (den_q == '0) begin
            slope_q <= '0;
            sv_q    <= 1'b0;
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_res.done) begin
            slope_q <= slope_d;
            sv_q    <= 1'b1;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_hgt_q   <= hgt_q;
            out_slope_q <= slope_q;
            out_sv_q    <= sv_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_slope_q, out_hgt_q};
  assign m_axis_tuser_o  = out_sv_q;

  `include "sliding_window_slope_estimator_unit_assert.svh"

  `SWSE_ASSERT(a_slot_range, 1'b1, wr_slot_q <= IdxW'(WINDOW - 1))
  `SWSE_ASSERT(a_invalid_zero, m_axis_tvalid_o && !m_axis_tuser_o[0], m_axis_tdata_o[48:17] == '0)
  `SWSE_ASSERT(a_div_den, div_start, den_q != '0)
  `SWSE_ASSERT_NXT(a_busy_after_accept, in_acc, !s_axis_tready_o)

endmodule
`default_nettype wire

// ===== hw/rtl/swse_ring.sv =====
`default_nettype none
module swse_ring #(
  parameter int WINDOW = swse_pkg::WindowDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           wr_en_i,
  input  wire logic [$clog2(WINDOW)-1:0]      wr_addr_i,
  input  wire logic [swse_pkg::TickW-1:0]     wr_tick_i,
  input  wire logic signed [swse_pkg::HgtW-1:0] wr_hgt_i,
  input  wire logic                           rd_en_i,
  input  wire logic [$clog2(WINDOW)-1:0]      rd_addr_i,
  output logic      [swse_pkg::TickW-1:0]     rd_tick_o,
  output logic signed [swse_pkg::HgtW-1:0]    rd_hgt_o
);
  import swse_pkg::*;

  logic [TickW-1:0]        tick_mem [WINDOW];
  logic signed [HgtW-1:0]  hgt_mem  [WINDOW];
  logic [WINDOW-1:0]       valid_q;
  logic [TickW-1:0]        tick_rd_q;
  logic signed [HgtW-1:0]  hgt_rd_q;
  logic                    vld_rd_q;

  // Entry storage, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      tick_mem[wr_addr_i] <= wr_tick_i;
      hgt_mem[wr_addr_i]  <= wr_hgt_i;
    end
    if (rd_en_i) begin
      tick_rd_q <= tick_mem[rd_addr_i];
      hgt_rd_q  <= hgt_mem[rd_addr_i];
    end
  end

  // Valid bits: an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        vld_rd_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_tick_o = vld_rd_q ? tick_rd_q : '0;
  assign rd_hgt_o  = vld_rd_q ? hgt_rd_q : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/swse_mul.sv =====
`default_nettype none
module swse_mul (
  input  wire logic                             clk_i,
  input  wire swse_pkg::mul_req_t               req_i,
  output logic signed [swse_pkg::ProdW-1:0]     prod_o
);
  import swse_pkg::*;

  logic signed [ProdW-1:0] prod_q;

  // One signed multiply, product registered
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(req_i.a) * ProdW'(req_i.b);
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// ===== hw/rtl/swse_div.sv =====
`default_nettype none
module swse_div #(
  parameter int NW = 80,
  parameter int DW = 73
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output swse_pkg::div_res_t res_o
);
  import swse_pkg::*;

  localparam int CntW = $clog2(NW + 1);

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [NW-1:0]     dvd_q;
  logic [DW-1:0]     den_q;
  logic [DW-1:0]     rem_q;
  logic [SlopeW-1:0] quo_q;
  logic              ovf_q;
  logic [DW:0]       rem_sh;
  logic              ge;

  // One restoring step per cycle
  assign rem_sh = {rem_q, dvd_q[NW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NW);
        dvd_q  <= dividend_i;
        den_q  <= divisor_i;
        rem_q  <= '0;
        quo_q  <= '0;
        ovf_q  <= 1'b0;
      end else if (busy_q) begin
        rem_q <= ge ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
        quo_q <= {quo_q[SlopeW-2:0], ge};
        ovf_q <= ovf_q | quo_q[SlopeW-1];
        dvd_q <= dvd_q << 1;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.ovf  = ovf_q;
  assign res_o.quot = quo_q;

endmodule
`default_nettype wire
